// File: rtl/kskr_pkg.sv
// Shared types and constants for the KS C 5601 / ISO-2022-KR byte decoder.
package kskr_pkg;

  // Field widths
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned CodeWidth     = 32;
  localparam int unsigned AccumWidth    = 24;
  localparam int unsigned ApbAddrWidth  = 3;
  localparam int unsigned ApbDataWidth  = 32;

  // Register map (word index)
  localparam logic RegIdxInputMode = 1'b0;

  // Input mode codes
  localparam logic ModeKs  = 1'b0;
  localparam logic ModeIso = 1'b1;

  // Byte values with special meaning
  localparam logic [ByteWidth-1:0] LeadJamo = 8'hA4;
  localparam logic [ByteWidth-1:0] LeadFill = 8'hD4;
  localparam logic [ByteWidth-1:0] LeadHan3 = 8'h8F;
  localparam logic [ByteWidth-1:0] LeadNone = 8'h00;
  localparam logic [ByteWidth-1:0] ChSo     = 8'h0E;
  localparam logic [ByteWidth-1:0] ChSi     = 8'h0F;
  localparam logic [ByteWidth-1:0] ChSp     = 8'h20;
  localparam logic [ByteWidth-1:0] ChTab    = 8'h09;

  // Upper half of the two-byte KS codes
  localparam logic [15:0] KsPrefix = 16'h8FFB;

  // Word held between the input register and the decode stage
  typedef struct packed {
    logic                 valid;
    logic [ByteWidth-1:0] data;
  } kskr_item_t;

endpackage

// File: rtl/kskr_if.sv
// Valid/ready stream interfaces for the byte input and the code output.
interface kskr_byte_if
  import kskr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface kskr_code_if
  import kskr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CodeWidth-1:0] code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

// File: rtl/kskr_apb_regs.sv
// APB configuration register: holds the input mode.
module kskr_apb_regs
  import kskr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready,
  output logic                    input_mode_o
);

  logic mode_q, mode_d;
  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == RegIdxInputMode);
  assign wr_en  = psel && penable && pwrite && hit;

  // Mode register write
  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeKs;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Read back; unmapped addresses read zero
  assign prdata = hit ? {{(ApbDataWidth-1){1'b0}}, mode_q} : '0;

  assign input_mode_o = mode_q;

endmodule

// File: rtl/kskr_in_stage.sv
// Input register: captures one byte word and hands it to the decode stage.
module kskr_in_stage
  import kskr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  kskr_byte_if.sink  in_i,
  input  logic       advance_i,
  output kskr_item_t item_o
);

  logic                 valid_q, valid_d;
  logic [ByteWidth-1:0] data_q, data_d;
  logic                 take;

  // Free slot when empty or when the held word moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take) begin
      valid_d = 1'b1;
      data_d  = in_i.in_byte;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

// File: rtl/kskr_decode.sv
// Decode stage: decoder state, per-byte decode logic and result register.
module kskr_decode
  import kskr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        input_mode_i,
  input  kskr_item_t  item_i,
  output logic        advance_o,
  kskr_code_if.source out_o
);

  logic [ByteWidth-1:0]  lead_q, lead_d;
  logic [AccumWidth-1:0] accum_q, accum_d;
  logic                  fill_q, fill_d;
  logic                  shift_q, shift_d;
  logic                  out_valid_q, out_valid_d;
  logic [CodeWidth-1:0]  code_q, code_d;

  logic [CodeWidth-1:0]  res;
  logic [ByteWidth-1:0]  ks_c;
  logic                  use_ks;
  logic [AccumWidth-1:0] acc_new;

  // A word moves on when the result register is free or being emptied
  assign advance_o = item_i.valid && (!out_valid_q || out_o.ready);

  // Byte decode
  always_comb begin
    lead_d  = lead_q;
    accum_d = accum_q;
    fill_d  = fill_q;
    shift_d = shift_q;
    res     = '0;
    use_ks  = 1'b0;
    ks_c    = item_i.data;
    acc_new = accum_q;

    // ISO-2022-KR shift handling in front of the KS decoder
    if (input_mode_i == ModeIso) begin
      if (!shift_q) begin
        if (item_i.data != ChSo) begin
          res = {24'h0, item_i.data};
        end else begin
          shift_d = 1'b1;
        end
      end else if (item_i.data == ChSo) begin
        shift_d = 1'b0;
        res     = {24'h0, item_i.data};
      end else if (item_i.data == ChSi) begin
        shift_d = 1'b0;
      end else if (item_i.data == ChSp || item_i.data == ChTab) begin
        res = {24'h0, item_i.data};
      end else begin
        use_ks = 1'b1;
        ks_c   = item_i.data | 8'h80;
      end
    end else begin
      use_ks = 1'b1;
    end

    // KS C 5601 / three-byte group decoder
    if (use_ks) begin
      if (!ks_c[7]) begin
        lead_d = LeadNone;
        res    = {24'h0, ks_c};
      end else if (lead_q == LeadNone) begin
        lead_d = ks_c;
      end else if (lead_q == LeadJamo) begin
        if (ks_c == LeadFill) begin
          lead_d = LeadFill;
        end else begin
          lead_d = LeadNone;
          res    = {KsPrefix, LeadJamo, ks_c};
        end
      end else if (lead_q == LeadHan3 || lead_q == LeadFill) begin
        if (lead_q == LeadHan3 || fill_q) begin
          acc_new = {accum_q[AccumWidth-ByteWidth-1:0], ks_c};
          fill_d  = 1'b0;
        end else if (ks_c == LeadJamo) begin
          fill_d = 1'b1;
        end
        accum_d = acc_new;
        // Group complete once the accumulator reaches its top byte
        if (acc_new[AccumWidth-1:16] != '0) begin
          res     = {lead_q, acc_new};
          accum_d = '0;
          lead_d  = LeadNone;
        end
      end else begin
        lead_d = LeadNone;
        res    = {KsPrefix, lead_q, ks_c};
      end
    end
  end

  // Result register control
  always_comb begin
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
      code_d      = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= LeadNone;
      accum_q     <= '0;
      fill_q      <= 1'b0;
      shift_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        lead_q  <= lead_d;
        accum_q <= accum_d;
        fill_q  <= fill_d;
        shift_q <= shift_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.code  = code_q;

endmodule

// File: rtl/ks_iso2022kr_byte_decoder_top.sv
// Top level of the KS C 5601 / ISO-2022-KR byte decoder.
// Decodes one byte word per clock and returns one 32-bit code word for every
// byte (0 when no character is complete yet). A byte passes an input register
// and then the decode stage, whose result register drives the output;
// throughput is one byte per cycle, set by the update of the lead/accumulator
// state in the decode stage as each byte moves on. Both registers stall
// together under output backpressure.
// The input mode is set over the APB port at address 0 and should only be
// changed while no byte is in flight; all decoder state is kept across a
// mode change.
module ks_iso2022kr_byte_decoder_top
  import kskr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  kskr_byte_if.sink               in_i,
  kskr_code_if.source             out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  logic       input_mode;
  logic       advance;
  kskr_item_t item;

  // Configuration register
  kskr_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .input_mode_o (input_mode)
  );

  // Input register
  kskr_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (item)
  );

  // Decode and result register
  kskr_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .input_mode_i (input_mode),
    .item_i       (item),
    .advance_o    (advance),
    .out_o        (out_o)
  );

endmodule
